@@ rtl/core/mcaa_pkg.sv @@
// shared constants, codes and types of the mesh cell area accumulator
package mcaa_pkg;

  localparam int MAX_VERTS = 1024;
  localparam int MAX_CELLS = 1024;

  localparam int VIDX_W = $clog2(MAX_VERTS);
  localparam int VCNT_W = $clog2(MAX_VERTS + 1);
  localparam int CIDX_W = (MAX_CELLS > 1) ? $clog2(MAX_CELLS) : 1;

  localparam int KIND_W    = 2;
  localparam int ID_W      = 31;
  localparam int COORD_W   = 24;
  localparam int CELL_W    = 11;
  localparam int STATUS_W  = 2;
  localparam int PROD_W    = 2 * COORD_W;
  localparam int CONTRIB_W = 49;
  localparam int AREA_W    = 64;
  localparam int LOADED_W  = 11;

  localparam int IN_FIELDS_W  = ID_W + 2 * COORD_W + 2 * ID_W + 3 * CELL_W;
  localparam int IN_DATA_W    = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int IN_USER_W    = KIND_W;
  localparam int OUT_FIELDS_W = STATUS_W + CONTRIB_W + AREA_W + LOADED_W;
  localparam int OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;

  localparam logic [KIND_W-1:0] KIND_LOAD = 2'd0;
  localparam logic [KIND_W-1:0] KIND_EDGE = 2'd1;
  localparam logic [KIND_W-1:0] KIND_READ = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL      = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd2;
  localparam logic [STATUS_W-1:0] ST_RANGE     = 2'd3;

  typedef struct packed {
    logic [ID_W-1:0]           id;
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
  } vert_t;

endpackage

@@ rtl/core/mesh_cell_area_accumulator_core.sv @@
// top level of the mesh cell area accumulator: vertex store, edge search and cell sums
//
// usage
// - input stream (in_*): in_tuser carries the item kind (load vertex, process edge,
//   read cell area), in_tdata the remaining fields; one item per transfer
// - result stream (out_*): exactly one result transfer per input item, in order
// - a vertex load writes the next free entry of a 1024 deep vertex store; an edge
//   scans the stored ids one entry a cycle (memory read port) for both endpoints,
//   then one shared 24x24 multiplier forms x2*y1 and x1*y2 in two passes and a
//   shared 65-bit saturating adder updates the left and right cell sums with a
//   read-modify-write on the cell sum memory
// - the id scan dominates the time an edge takes; items are taken one at a time
// - reset: vertex count goes to zero; the cell sum memory is then swept to zero,
//   one entry a cycle, so in_tready stays low after reset until the sweep is done
// - stall: the finished result sits in an output register; the next item is
//   accepted while it waits, but that item's result waits until out_tready
module mesh_cell_area_accumulator_core (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  // tdata from bit 0: vertex_id, vertex_x, vertex_y, first_vertex_id,
  // second_vertex_id, left_cell, right_cell, cell_number, zero pad
  input  logic [mcaa_pkg::IN_DATA_W-1:0] in_tdata,
  // tuser: kind
  input  logic [mcaa_pkg::IN_USER_W-1:0] in_tuser,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // tdata from bit 0: status, edge_contribution, cell_area, vertices_loaded, zero pad
  output logic [mcaa_pkg::OUT_DATA_W-1:0] out_tdata
);
  import mcaa_pkg::*;

  // field offsets inside in_tdata
  localparam int OFS_VX  = ID_W;
  localparam int OFS_VY  = OFS_VX + COORD_W;
  localparam int OFS_ID1 = OFS_VY + COORD_W;
  localparam int OFS_ID2 = OFS_ID1 + ID_W;
  localparam int OFS_LC  = OFS_ID2 + ID_W;
  localparam int OFS_RC  = OFS_LC + CELL_W;
  localparam int OFS_CN  = OFS_RC + CELL_W;
  localparam int OUT_PAD_W = OUT_DATA_W - OUT_FIELDS_W;

  // sequencer states
  localparam logic [3:0] S_CLR   = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_SRCH  = 4'd2;
  localparam logic [3:0] S_MUL1  = 4'd3;
  localparam logic [3:0] S_MUL2  = 4'd4;
  localparam logic [3:0] S_SUB   = 4'd5;
  localparam logic [3:0] S_LRD   = 4'd6;
  localparam logic [3:0] S_LWR   = 4'd7;
  localparam logic [3:0] S_RRD   = 4'd8;
  localparam logic [3:0] S_RWR   = 4'd9;
  localparam logic [3:0] S_CRD   = 4'd10;
  localparam logic [3:0] S_CWAIT = 4'd11;
  localparam logic [3:0] S_DONE  = 4'd12;

  localparam logic signed [AREA_W-1:0] SUM_MAX = {1'b0, {(AREA_W-1){1'b1}}};
  localparam logic signed [AREA_W-1:0] SUM_MIN = {1'b1, {(AREA_W-1){1'b0}}};

  // input fields
  logic [KIND_W-1:0]         in_kind;
  logic [ID_W-1:0]           in_vertex_id;
  logic signed [COORD_W-1:0] in_vertex_x;
  logic signed [COORD_W-1:0] in_vertex_y;
  logic [ID_W-1:0]           in_first_vertex_id;
  logic [ID_W-1:0]           in_second_vertex_id;
  logic [CELL_W-1:0]         in_left_cell;
  logic [CELL_W-1:0]         in_right_cell;
  logic [CELL_W-1:0]         in_cell_number;

  assign in_kind             = in_tuser[KIND_W-1:0];
  assign in_vertex_id        = in_tdata[ID_W-1:0];
  assign in_vertex_x         = in_tdata[OFS_VX +: COORD_W];
  assign in_vertex_y         = in_tdata[OFS_VY +: COORD_W];
  assign in_first_vertex_id  = in_tdata[OFS_ID1 +: ID_W];
  assign in_second_vertex_id = in_tdata[OFS_ID2 +: ID_W];
  assign in_left_cell        = in_tdata[OFS_LC +: CELL_W];
  assign in_right_cell       = in_tdata[OFS_RC +: CELL_W];
  assign in_cell_number      = in_tdata[OFS_CN +: CELL_W];

  // control registers
  logic [3:0]        state_r, state_nxt;
  logic [VCNT_W-1:0] vcnt_r, vcnt_nxt;
  logic [VCNT_W-1:0] saddr_r, saddr_nxt;
  logic              rpend_r, rpend_nxt;
  logic              found1_r, found1_nxt;
  logic              found2_r, found2_nxt;
  logic [CIDX_W-1:0] clr_r, clr_nxt;
  logic              out_tvalid_r, out_tvalid_nxt;

  // payload registers
  logic [ID_W-1:0]             id1_r, id1_nxt;
  logic [ID_W-1:0]             id2_r, id2_nxt;
  logic [CELL_W-1:0]           lc_r, lc_nxt;
  logic [CELL_W-1:0]           rc_r, rc_nxt;
  logic [CELL_W-1:0]           cn_r, cn_nxt;
  logic signed [COORD_W-1:0]   x1_r, x1_nxt, y1_r, y1_nxt;
  logic signed [COORD_W-1:0]   x2_r, x2_nxt, y2_r, y2_nxt;
  logic signed [PROD_W-1:0]    p1_r, p1_nxt, p2_r, p2_nxt;
  logic signed [CONTRIB_W-1:0] contrib_r, contrib_nxt;
  logic signed [AREA_W-1:0]    area_r, area_nxt;
  logic [STATUS_W-1:0]         status_r, status_nxt;
  logic [OUT_DATA_W-1:0]       out_tdata_r, out_tdata_nxt;

  // vertex store
  vert_t             vmem [MAX_VERTS];
  vert_t             vm_rd_r;
  logic              vm_we, vm_re;
  logic [VIDX_W-1:0] vm_raddr;
  vert_t             vm_wdata;

  // cell sum memory
  logic signed [AREA_W-1:0] cmem [MAX_CELLS];
  logic signed [AREA_W-1:0] cm_rd_r;
  logic                     cm_we, cm_re;
  logic [CIDX_W-1:0]        cm_waddr, cm_raddr;
  logic signed [AREA_W-1:0] cm_wdata;

  // shared multiplier and saturating adder
  logic signed [COORD_W-1:0]   mul_a, mul_b;
  logic signed [PROD_W-1:0]    mul_p;
  logic signed [CONTRIB_W-1:0] add_b;
  logic signed [AREA_W:0]      add_sum;
  logic signed [AREA_W-1:0]    sat_sum;

  logic              in_xfer;
  logic              cells_bad;
  logic              match1, match2;
  logic [CIDX_W-1:0] lc_idx, rc_idx;

  assign in_tready  = (state_r == S_IDLE);
  assign in_xfer    = in_tvalid && in_tready;
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  assign lc_idx    = CIDX_W'(lc_r - CELL_W'(1));
  assign rc_idx    = CIDX_W'(rc_r - CELL_W'(1));
  assign cells_bad = (32'(lc_r) > 32'(MAX_CELLS)) || (32'(rc_r) > 32'(MAX_CELLS));
  assign match1    = rpend_r && !found1_r && (vm_rd_r.id == id1_r);
  assign match2    = rpend_r && !found2_r && (vm_rd_r.id == id2_r);

  always_comb begin
    mul_a = x2_r;
    mul_b = y1_r;
    if (state_r == S_MUL2) begin
      mul_a = x1_r;
      mul_b = y2_r;
    end
  end
  assign mul_p = mul_a * mul_b;

  // left cell takes minus the contribution, right cell plus
  assign add_b   = (state_r == S_LWR) ? -contrib_r : contrib_r;
  assign add_sum = (AREA_W+1)'(cm_rd_r) + (AREA_W+1)'(add_b);
  always_comb begin
    if (add_sum[AREA_W] != add_sum[AREA_W-1]) begin
      sat_sum = add_sum[AREA_W] ? SUM_MIN : SUM_MAX;
    end else begin
      sat_sum = add_sum[AREA_W-1:0];
    end
  end

  // sequencer
  always_comb begin
    state_nxt      = state_r;
    vcnt_nxt       = vcnt_r;
    saddr_nxt      = saddr_r;
    rpend_nxt      = 1'b0;
    found1_nxt     = found1_r;
    found2_nxt     = found2_r;
    clr_nxt        = clr_r;
    out_tvalid_nxt = out_tvalid_r;
    id1_nxt        = id1_r;
    id2_nxt        = id2_r;
    lc_nxt         = lc_r;
    rc_nxt         = rc_r;
    cn_nxt         = cn_r;
    x1_nxt         = x1_r;
    y1_nxt         = y1_r;
    x2_nxt         = x2_r;
    y2_nxt         = y2_r;
    p1_nxt         = p1_r;
    p2_nxt         = p2_r;
    contrib_nxt    = contrib_r;
    area_nxt       = area_r;
    status_nxt     = status_r;
    out_tdata_nxt  = out_tdata_r;
    vm_we          = 1'b0;
    vm_re          = 1'b0;
    vm_raddr       = saddr_r[VIDX_W-1:0];
    vm_wdata       = '{id: in_vertex_id, x: in_vertex_x, y: in_vertex_y};
    cm_we          = 1'b0;
    cm_re          = 1'b0;
    cm_waddr       = clr_r;
    cm_raddr       = lc_idx;
    cm_wdata       = '0;

    if (out_tvalid_r && out_tready) begin
      out_tvalid_nxt = 1'b0;
    end

    case (state_r)
      S_CLR: begin
        cm_we = 1'b1;
        clr_nxt = clr_r + CIDX_W'(1);
        if (clr_r == CIDX_W'(MAX_CELLS - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_xfer) begin
          status_nxt  = ST_OK;
          contrib_nxt = '0;
          area_nxt    = '0;
          id1_nxt     = in_first_vertex_id;
          id2_nxt     = in_second_vertex_id;
          lc_nxt      = in_left_cell;
          rc_nxt      = in_right_cell;
          cn_nxt      = in_cell_number;
          found1_nxt  = 1'b0;
          found2_nxt  = 1'b0;
          saddr_nxt   = '0;
          state_nxt   = S_DONE;
          case (in_kind)
            KIND_LOAD: begin
              if (vcnt_r >= VCNT_W'(MAX_VERTS)) begin
                status_nxt = ST_FULL;
              end else begin
                vm_we    = 1'b1;
                vcnt_nxt = vcnt_r + VCNT_W'(1);
              end
            end
            KIND_EDGE: state_nxt = S_SRCH;
            KIND_READ: begin
              if ((in_cell_number == '0) ||
                  (32'(in_cell_number) > 32'(MAX_CELLS))) begin
                status_nxt = ST_RANGE;
              end else begin
                state_nxt = S_CRD;
              end
            end
            default: ;
          endcase
        end
      end
      S_SRCH: begin
        // one stored entry issued and one compared per cycle
        if (match1) begin
          found1_nxt = 1'b1;
          x1_nxt     = vm_rd_r.x;
          y1_nxt     = vm_rd_r.y;
        end
        if (match2) begin
          found2_nxt = 1'b1;
          x2_nxt     = vm_rd_r.x;
          y2_nxt     = vm_rd_r.y;
        end
        if (found1_r && found2_r) begin
          state_nxt = S_MUL1;
        end else if ((saddr_r >= vcnt_r) && !rpend_r) begin
          status_nxt = ST_NOT_FOUND;
          state_nxt  = S_DONE;
        end else if (saddr_r < vcnt_r) begin
          vm_re     = 1'b1;
          rpend_nxt = 1'b1;
          saddr_nxt = saddr_r + VCNT_W'(1);
        end
      end
      S_MUL1: begin
        p1_nxt    = mul_p;
        state_nxt = S_MUL2;
      end
      S_MUL2: begin
        p2_nxt    = mul_p;
        state_nxt = S_SUB;
      end
      S_SUB: begin
        contrib_nxt = CONTRIB_W'(p1_r) - CONTRIB_W'(p2_r);
        if (cells_bad) begin
          status_nxt = ST_RANGE;
          state_nxt  = S_DONE;
        end else if (lc_r != '0) begin
          state_nxt = S_LRD;
        end else if (rc_r != '0) begin
          state_nxt = S_RRD;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_LRD: begin
        cm_re     = 1'b1;
        state_nxt = S_LWR;
      end
      S_LWR: begin
        cm_we     = 1'b1;
        cm_waddr  = lc_idx;
        cm_wdata  = sat_sum;
        state_nxt = (rc_r != '0) ? S_RRD : S_DONE;
      end
      S_RRD: begin
        cm_re     = 1'b1;
        cm_raddr  = rc_idx;
        state_nxt = S_RWR;
      end
      S_RWR: begin
        cm_we     = 1'b1;
        cm_waddr  = rc_idx;
        cm_wdata  = sat_sum;
        state_nxt = S_DONE;
      end
      S_CRD: begin
        cm_re     = 1'b1;
        cm_raddr  = CIDX_W'(cn_r - CELL_W'(1));
        state_nxt = S_CWAIT;
      end
      S_CWAIT: begin
        area_nxt  = cm_rd_r;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        // hand the result over once the output register is free
        if (!out_tvalid_r || out_tready) begin
          out_tvalid_nxt = 1'b1;
          out_tdata_nxt  = {{OUT_PAD_W{1'b0}}, LOADED_W'(vcnt_r), area_r, contrib_r,
                            status_r};
          state_nxt      = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLR;
      vcnt_r       <= '0;
      saddr_r      <= '0;
      rpend_r      <= 1'b0;
      found1_r     <= 1'b0;
      found2_r     <= 1'b0;
      clr_r        <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      vcnt_r       <= vcnt_nxt;
      saddr_r      <= saddr_nxt;
      rpend_r      <= rpend_nxt;
      found1_r     <= found1_nxt;
      found2_r     <= found2_nxt;
      clr_r        <= clr_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    id1_r       <= id1_nxt;
    id2_r       <= id2_nxt;
    lc_r        <= lc_nxt;
    rc_r        <= rc_nxt;
    cn_r        <= cn_nxt;
    x1_r        <= x1_nxt;
    y1_r        <= y1_nxt;
    x2_r        <= x2_nxt;
    y2_r        <= y2_nxt;
    p1_r        <= p1_nxt;
    p2_r        <= p2_nxt;
    contrib_r   <= contrib_nxt;
    area_r      <= area_nxt;
    status_r    <= status_nxt;
    out_tdata_r <= out_tdata_nxt;
  end

  // vertex store: write at the fill count, read at the scan address
  always_ff @(posedge clk) begin
    if (vm_we) begin
      vmem[vcnt_r[VIDX_W-1:0]] <= vm_wdata;
    end
    if (vm_re) begin
      vm_rd_r <= vmem[vm_raddr];
    end
  end

  // cell sum memory: one write and one read port
  always_ff @(posedge clk) begin
    if (cm_we) begin
      cmem[cm_waddr] <= cm_wdata;
    end
    if (cm_re) begin
      cm_rd_r <= cmem[cm_raddr];
    end
  end

  // checks
  a_vcnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    vcnt_r <= VCNT_W'(MAX_VERTS))
    else $error("vertex count above store depth");

  a_load_bumps: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer && (in_kind == KIND_LOAD) && (vcnt_r < VCNT_W'(MAX_VERTS))
    |=> vcnt_r == $past(vcnt_r) + VCNT_W'(1))
    else $error("vertex load did not advance the fill count");

  a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SRCH) |-> saddr_r <= vcnt_r)
    else $error("id scan ran past the filled entries");

  a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid_r && (out_tdata_r[STATUS_W-1:0] == ST_FULL)
    |-> vcnt_r == VCNT_W'(MAX_VERTS))
    else $error("store full reported while entries remain");

  a_notfound_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid_r && (out_tdata_r[STATUS_W-1:0] == ST_NOT_FOUND)
    |-> out_tdata_r[STATUS_W +: CONTRIB_W] == '0)
    else $error("missing vertex but nonzero contribution");

endmodule
